/* hdl/rbsi_pkg.sv */
package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int NW        = DW + FRAC_BITS;
  localparam int TW        = NW + 2;
  localparam int EPS_W     = 17;
  localparam int QW        = DW + 9;
  localparam int PW        = 2 * DW - FRAC_BITS + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_EPS  = 3'd6;

  localparam logic signed [TW-1:0] T_POS_INF = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] T_NEG_INF = {1'b1, {(TW-1){1'b0}}};
  localparam logic [QW-1:0] Q_MAX = QW'(1) << (QW - 1);

  typedef struct packed {
    logic signed [DW-1:0] origin_x;
    logic signed [DW-1:0] origin_y;
    logic signed [DW-1:0] origin_z;
    logic signed [DW-1:0] dir_x;
    logic signed [DW-1:0] dir_y;
    logic signed [DW-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [DW-1:0] hit_distance;
    logic signed [DW-1:0] point_x;
    logic signed [DW-1:0] point_y;
    logic signed [DW-1:0] point_z;
  } out_t;

  function automatic logic signed [DW-1:0] sat_t(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] hi_lim;
    logic signed [TW-1:0] lo_lim;
    hi_lim = TW'({1'b0, {(DW-1){1'b1}}});
    lo_lim = -hi_lim - TW'(1);
    if (v > hi_lim) begin
      sat_t = {1'b0, {(DW-1){1'b1}}};
    end else if (v < lo_lim) begin
      sat_t = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat_t = v[DW-1:0];
    end
  endfunction

endpackage

/* hdl/rbsi_div.sv */
module rbsi_div import rbsi_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] acc_r [NW];
  logic [DW-1:0] den_r [NW-1];
  logic [DW-1:0] rem_p [NW];
  logic [NW-1:0] acc_p [NW];
  logic [DW-1:0] den_p [NW];

  always_comb begin
    rem_p[0] = '0;
    acc_p[0] = num_i;
    den_p[0] = den_i;
    for (int k = 1; k < NW; k++) begin
      rem_p[k] = rem_r[k-1];
      acc_p[k] = acc_r[k-1];
      den_p[k] = den_r[k-1];
    end
  end

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    assign trial = {rem_p[k], acc_p[k][NW-1]};
    assign ge    = trial >= {1'b0, den_p[k]};
    assign diff  = trial - {1'b0, den_p[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        acc_r[k] <= {acc_p[k][NW-2:0], ge};
      end
    end

    if (k < NW - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[k] <= den_p[k];
        end
      end
    end
  end

  assign quo_o = acc_r[NW-1];

endmodule

/* hdl/ray_box_slab_intersect_top.sv */
// coordinates, distances and points are Q16.16 fixed point
// throughput: one ray per cycle unless stalled; the slab divides are bit-per-stage pipelines
// the whole pipeline advances unless the result register is held by out_stall
// reset (rst_n low, synchronous) clears all valid bits, box corners to zero
// and exit epsilon to one
module ray_box_slab_intersect_top import rbsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DW-1:0]        cfg_data
);

  typedef struct packed {
    in_t        ray;
    logic [2:0] dz;
    logic [2:0] par_in;
    logic [2:0] sg_en;
    logic [2:0] sg_ex;
  } sb_t;

  logic signed [DW-1:0] box_min_r [3];
  logic signed [DW-1:0] box_max_r [3];
  logic [EPS_W-1:0]     eps_r;
  logic                 adv;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        box_min_r[a] <= '0;
        box_max_r[a] <= '0;
      end
      eps_r <= EPS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BOX_MIN_X: box_min_r[0] <= cfg_data;
        CFG_BOX_MIN_Y: box_min_r[1] <= cfg_data;
        CFG_BOX_MIN_Z: box_min_r[2] <= cfg_data;
        CFG_BOX_MAX_X: box_max_r[0] <= cfg_data;
        CFG_BOX_MAX_Y: box_max_r[1] <= cfg_data;
        CFG_BOX_MAX_Z: box_max_r[2] <= cfg_data;
        CFG_EXIT_EPS:  eps_r        <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: slab offsets
  logic signed [DW-1:0] o_in [3];
  logic signed [DW-1:0] d_in [3];
  assign o_in[0] = in_data.origin_x;
  assign o_in[1] = in_data.origin_y;
  assign o_in[2] = in_data.origin_z;
  assign d_in[0] = in_data.dir_x;
  assign d_in[1] = in_data.dir_y;
  assign d_in[2] = in_data.dir_z;

  logic                 s1_v_r;
  in_t                  s1_ray_r;
  logic signed [DW:0]   s1_nlo_r [3];
  logic signed [DW:0]   s1_nhi_r [3];
  logic [2:0]           s1_in_r;
  logic [2:0]           s1_neg_r;
  logic [2:0]           s1_dz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ray_r <= in_data;
      for (int a = 0; a < 3; a++) begin
        s1_nlo_r[a] <= {box_min_r[a][DW-1], box_min_r[a]} - {o_in[a][DW-1], o_in[a]};
        s1_nhi_r[a] <= {box_max_r[a][DW-1], box_max_r[a]} - {o_in[a][DW-1], o_in[a]};
        s1_in_r[a]  <= (o_in[a] >= box_min_r[a]) && (o_in[a] <= box_max_r[a]);
        s1_neg_r[a] <= d_in[a][DW-1];
        s1_dz_r[a]  <= d_in[a] == '0;
      end
    end
  end

  // stage 2: divider operands
  logic signed [DW-1:0] s1_d [3];
  assign s1_d[0] = s1_ray_r.dir_x;
  assign s1_d[1] = s1_ray_r.dir_y;
  assign s1_d[2] = s1_ray_r.dir_z;

  logic          s2_v_r;
  sb_t           s2_sb_r;
  logic [NW-1:0] s2_num_en_r [3];
  logic [NW-1:0] s2_num_ex_r [3];
  logic [DW-1:0] s2_den_r [3];

  always_ff @(posedge clk) begin
    logic signed [DW:0] n_en;
    logic signed [DW:0] n_ex;
    logic [DW:0]        m_en;
    logic [DW:0]        m_ex;
    if (adv) begin
      s2_sb_r.ray    <= s1_ray_r;
      s2_sb_r.dz     <= s1_dz_r;
      s2_sb_r.par_in <= s1_in_r;
      for (int a = 0; a < 3; a++) begin
        n_en = s1_neg_r[a] ? s1_nhi_r[a] : s1_nlo_r[a];
        n_ex = s1_neg_r[a] ? s1_nlo_r[a] : s1_nhi_r[a];
        m_en = n_en[DW] ? (DW+1)'(0) - n_en : n_en;
        m_ex = n_ex[DW] ? (DW+1)'(0) - n_ex : n_ex;
        s2_num_en_r[a]   <= {m_en[DW-1:0], {FRAC_BITS{1'b0}}};
        s2_num_ex_r[a]   <= {m_ex[DW-1:0], {FRAC_BITS{1'b0}}};
        s2_den_r[a]      <= s1_neg_r[a] ? DW'(0) - s1_d[a] : s1_d[a];
        s2_sb_r.sg_en[a] <= n_en[DW] ^ s1_neg_r[a];
        s2_sb_r.sg_ex[a] <= n_ex[DW] ^ s1_neg_r[a];
      end
    end
  end

  logic [NW-1:0] quo_en [3];
  logic [NW-1:0] quo_ex [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_div u_div_en (
      .clk   (clk),
      .en    (adv),
      .num_i (s2_num_en_r[a]),
      .den_i (s2_den_r[a]),
      .quo_o (quo_en[a])
    );
    rbsi_div u_div_ex (
      .clk   (clk),
      .en    (adv),
      .num_i (s2_num_ex_r[a]),
      .den_i (s2_den_r[a]),
      .quo_o (quo_ex[a])
    );
  end

  logic dv_r [NW];
  sb_t  sb_r [NW];

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= s2_sb_r;
      for (int k = 1; k < NW; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  // stage 3: signed slab distances, parallel slabs
  logic                 s3_v_r;
  sb_t                  s3_sb_r;
  logic signed [TW-1:0] s3_en_r [3];
  logic signed [TW-1:0] s3_ex_r [3];

  always_ff @(posedge clk) begin
    logic signed [TW-1:0] qe;
    logic signed [TW-1:0] qx;
    if (adv) begin
      s3_sb_r <= sb_r[NW-1];
      for (int a = 0; a < 3; a++) begin
        qe = {2'b00, quo_en[a]};
        qx = {2'b00, quo_ex[a]};
        if (sb_r[NW-1].dz[a]) begin
          s3_en_r[a] <= sb_r[NW-1].par_in[a] ? T_NEG_INF : T_POS_INF;
          s3_ex_r[a] <= sb_r[NW-1].par_in[a] ? T_POS_INF : T_NEG_INF;
        end else begin
          s3_en_r[a] <= sb_r[NW-1].sg_en[a] ? -qe : qe;
          s3_ex_r[a] <= sb_r[NW-1].sg_ex[a] ? -qx : qx;
        end
      end
    end
  end

  // stages 4 and 5: largest entry, smallest exit
  logic                 s4_v_r;
  sb_t                  s4_sb_r;
  logic signed [TW-1:0] s4_en01_r;
  logic signed [TW-1:0] s4_ex01_r;
  logic signed [TW-1:0] s4_en2_r;
  logic signed [TW-1:0] s4_ex2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sb_r   <= s3_sb_r;
      s4_en01_r <= (s3_en_r[0] > s3_en_r[1]) ? s3_en_r[0] : s3_en_r[1];
      s4_ex01_r <= (s3_ex_r[0] < s3_ex_r[1]) ? s3_ex_r[0] : s3_ex_r[1];
      s4_en2_r  <= s3_en_r[2];
      s4_ex2_r  <= s3_ex_r[2];
    end
  end

  logic                 s5_v_r;
  sb_t                  s5_sb_r;
  logic signed [TW-1:0] s5_t0_r;
  logic signed [TW-1:0] s5_t1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sb_r <= s4_sb_r;
      s5_t0_r <= (s4_en01_r > s4_en2_r) ? s4_en01_r : s4_en2_r;
      s5_t1_r <= (s4_ex01_r < s4_ex2_r) ? s4_ex01_r : s4_ex2_r;
    end
  end

  // stage 6: hit decision, distance choice
  logic signed [DW-1:0] s5_d [3];
  assign s5_d[0] = s5_sb_r.ray.dir_x;
  assign s5_d[1] = s5_sb_r.ray.dir_y;
  assign s5_d[2] = s5_sb_r.ray.dir_z;

  logic signed [TW-1:0] s6_t;
  logic signed [TW-1:0] s6_t_abs;
  assign s6_t     = (s5_t0_r >= 0) ? s5_t0_r : s5_t1_r;
  assign s6_t_abs = s6_t[TW-1] ? -s6_t : s6_t;

  logic                 s6_v_r;
  in_t                  s6_ray_r;
  logic [2:0]           s6_dz_r;
  logic                 s6_hit_r;
  logic                 s6_inf_r;
  logic signed [TW-1:0] s6_t_r;
  logic [NW-1:0]        s6_mt_r;
  logic [DW-1:0]        s6_md_r [3];
  logic [2:0]           s6_neg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_ray_r <= s5_sb_r.ray;
      s6_dz_r  <= s5_sb_r.dz;
      s6_hit_r <= (s5_t0_r < s5_t1_r) &&
                  (s5_t1_r > $signed({{(TW-EPS_W){1'b0}}, eps_r}));
      s6_inf_r <= (s6_t == T_POS_INF) || (s6_t == T_NEG_INF);
      s6_t_r   <= s6_t;
      s6_mt_r  <= s6_t_abs[NW-1:0];
      for (int a = 0; a < 3; a++) begin
        s6_md_r[a]  <= s5_d[a][DW-1] ? DW'(0) - s5_d[a] : s5_d[a];
        s6_neg_r[a] <= s6_t[TW-1] ^ s5_d[a][DW-1];
      end
    end
  end

  // stage 7: partial products of t * dir
  logic                  s7_v_r;
  in_t                   s7_ray_r;
  logic [2:0]            s7_dz_r;
  logic                  s7_hit_r;
  logic                  s7_inf_r;
  logic signed [TW-1:0]  s7_t_r;
  logic [2:0]            s7_neg_r;
  logic [2*DW-1:0]       s7_lo_r [3];
  logic [NW-1:0]         s7_hi_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_ray_r <= s6_ray_r;
      s7_dz_r  <= s6_dz_r;
      s7_hit_r <= s6_hit_r;
      s7_inf_r <= s6_inf_r;
      s7_t_r   <= s6_t_r;
      s7_neg_r <= s6_neg_r;
      for (int a = 0; a < 3; a++) begin
        s7_lo_r[a] <= {{DW{1'b0}}, s6_mt_r[DW-1:0]} * {{DW{1'b0}}, s6_md_r[a]};
        s7_hi_r[a] <= {{DW{1'b0}}, s6_mt_r[NW-1:DW]} * {{FRAC_BITS{1'b0}}, s6_md_r[a]};
      end
    end
  end

  // stage 8: scaled product, clamped
  logic                 s8_v_r;
  in_t                  s8_ray_r;
  logic [2:0]           s8_dz_r;
  logic                 s8_hit_r;
  logic                 s8_inf_r;
  logic signed [TW-1:0] s8_t_r;
  logic [2:0]           s8_neg_r;
  logic [QW-1:0]        s8_q_r [3];

  always_ff @(posedge clk) begin
    logic [PW-1:0] sum;
    if (adv) begin
      s8_ray_r <= s7_ray_r;
      s8_dz_r  <= s7_dz_r;
      s8_hit_r <= s7_hit_r;
      s8_inf_r <= s7_inf_r;
      s8_t_r   <= s7_t_r;
      s8_neg_r <= s7_neg_r;
      for (int a = 0; a < 3; a++) begin
        sum = PW'(s7_hi_r[a][DW-1:0] << (DW - FRAC_BITS)) + PW'(s7_lo_r[a] >> FRAC_BITS);
        if ((s7_hi_r[a] >= (NW'(1) << FRAC_BITS)) || (sum > PW'(Q_MAX))) begin
          s8_q_r[a] <= Q_MAX;
        end else begin
          s8_q_r[a] <= sum[QW-1:0];
        end
      end
    end
  end

  // stage 9: hit point, result register
  logic signed [DW-1:0] s8_o [3];
  assign s8_o[0] = s8_ray_r.origin_x;
  assign s8_o[1] = s8_ray_r.origin_y;
  assign s8_o[2] = s8_ray_r.origin_z;

  logic signed [DW-1:0] pt [3];

  always_comb begin
    logic signed [QW+1:0] ow;
    logic signed [QW+1:0] qw;
    logic signed [QW+1:0] pw;
    for (int a = 0; a < 3; a++) begin
      ow = (QW+2)'(s8_o[a]);
      qw = $signed({2'b00, s8_q_r[a]});
      pw = s8_neg_r[a] ? ow - qw : ow + qw;
      if (s8_dz_r[a] || s8_inf_r) begin
        pt[a] = s8_o[a];
      end else if (pw > (QW+2)'(32'sh7fffffff)) begin
        pt[a] = {1'b0, {(DW-1){1'b1}}};
      end else if (pw < -(QW+2)'(32'sh7fffffff) - (QW+2)'(1)) begin
        pt[a] = {1'b1, {(DW-1){1'b0}}};
      end else begin
        pt[a] = pw[DW-1:0];
      end
    end
  end

  out_t out_data_r;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.hit          <= s8_hit_r;
      out_data_r.hit_distance <= s8_hit_r ? sat_t(s8_t_r) : '0;
      out_data_r.point_x      <= s8_hit_r ? pt[0] : '0;
      out_data_r.point_y      <= s8_hit_r ? pt[1] : '0;
      out_data_r.point_z      <= s8_hit_r ? pt[2] : '0;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      for (int k = 0; k < NW; k++) begin
        dv_r[k] <= 1'b0;
      end
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      s7_v_r      <= 1'b0;
      s8_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      dv_r[0] <= s2_v_r;
      for (int k = 1; k < NW; k++) begin
        dv_r[k] <= dv_r[k-1];
      end
      s3_v_r      <= dv_r[NW-1];
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= s5_v_r;
      s7_v_r      <= s6_v_r;
      s8_v_r      <= s7_v_r;
      out_valid_r <= s8_v_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.hit_distance == '0 &&
      out_data.point_x == '0 && out_data.point_y == '0 && out_data.point_z == '0)
    else $error("miss result carries nonzero fields");

  a_hit_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> !out_data.hit_distance[DW-1])
    else $error("hit with negative distance");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(s8_v_r) && $stable(s1_v_r))
    else $error("pipeline moved while stalled");

endmodule
